FILE: design/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

	// Pattern byte value that matches any data byte.
	localparam logic [7:0] WILDCARD_BYTE = 8'hCC;

	// Number of pattern bytes held in the two pattern registers.
	localparam int PATTERN_REG_BYTES = 16;

	// Width of the pattern length register and of the reported offset.
	localparam int LEN_REG_W    = 5;
	localparam int OFFSET_OUT_W = 32;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PAT_LO = 2'd0;
	localparam logic [1:0] CFG_PAT_HI = 2'd1;
	localparam logic [1:0] CFG_LEN    = 2'd2;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_SHORT     = 2'd3
	} status_t;

	// Control marks of the item held in the first pipeline stage.
	typedef struct packed {
		logic valid;
		logic start;
		logic last;
	} item_ctl_t;

endpackage

FILE: design/wildcard_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Streams the bytes of a region through a window and reports the first
// offset at which a configured pattern with 0xCC wildcards matches.
// ----------------------------------------------------------------------------
// The block takes one byte per item and a new item every cycle unless held off.
// An item passes two stages: in the first, the byte enters a row of window
// cells (the newest byte in the top cell, every cell handing its byte to the
// next older one) and the region byte count is advanced; in the second, all
// cells compare their bytes with the aligned pattern bytes in parallel, the
// first match of the region is latched and, on a byte marked as the last one,
// the single result item is written into the output register. Items keep
// flowing while a result waits in the output register; the input is held off
// only when a second last byte reaches the result stage before the first
// result has been taken. Status codes: 0 found (match_offset gives the
// offset from the region start), 1 not found, 2 empty pattern, 3 region
// shorter than the pattern; match_offset is zero unless the pattern was
// found. A byte marked as first clears the scan state, and so does the end
// of a region. The byte counter saturates at its maximum. A pattern length
// above MAX_PATTERN_BYTES counts as MAX_PATTERN_BYTES. Configuration
// registers: 0 pattern bytes 0-7, 1 pattern bytes 8-15, 2 pattern length
// (data bits 4:0), written through the always ready cfg port. The user must
// write them only while no region is in flight; the block does not check it.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int OFFSET_BITS       = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [63:0]                      cfg_data,
	// Input stream.
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
	input  logic                             s_axis_tuser,  // [0] region_start
	input  logic                             s_axis_tlast,  // region_end
	// Result stream.
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [wbps_pkg::OFFSET_OUT_W-1:0] m_axis_tdata, // [31:0] match_offset
	output logic [1:0]                       m_axis_tuser   // [1:0] scan_status
);
	import wbps_pkg::*;

	localparam int LEN_W  = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int CMP_W  = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PATTERN_BYTES);

	// Configuration registers.
	logic [63:0]          pat_lo_q;
	logic [63:0]          pat_hi_q;
	logic [LEN_REG_W-1:0] len_q;

	// First stage.
	item_ctl_t              ctl_s1;
	logic [OFFSET_BITS-1:0] cnt_s1;
	logic [OFFSET_BITS-1:0] cnt_q;
	logic [OFFSET_BITS-1:0] cnt_base;
	logic [OFFSET_BITS-1:0] cnt_nx;

	logic                   accept;
	logic                   stall;
	logic [CMP_W-1:0]       len_cmp;
	logic [LEN_W-1:0]       len_eff;
	logic [MAX_PATTERN_BYTES*8-1:0] pat_flat;
	logic [7:0]             chain [MAX_PATTERN_BYTES+1];
	logic [MAX_PATTERN_BYTES-1:0]   hits;
	logic                   win_match;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			len_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PAT_LO: pat_lo_q <= cfg_data;
				CFG_PAT_HI: pat_hi_q <= cfg_data;
				CFG_LEN:    len_q    <= cfg_data[LEN_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Lengths beyond the window are clamped to the window size.
	always_comb begin
		len_cmp = CMP_W'(len_q);
		if (len_cmp > MAX_CMP) begin
			len_cmp = MAX_CMP;
		end
		len_eff = len_cmp[LEN_W-1:0];
	end

	// Pattern bytes past the two registers act as wildcards.
	for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_pat
		if (j < PATTERN_REG_BYTES / 2) begin : g_lo
			assign pat_flat[j*8 +: 8] = pat_lo_q[j*8 +: 8];
		end else if (j < PATTERN_REG_BYTES) begin : g_hi
			assign pat_flat[j*8 +: 8] = pat_hi_q[(j - PATTERN_REG_BYTES / 2)*8 +: 8];
		end else begin : g_wild
			assign pat_flat[j*8 +: 8] = WILDCARD_BYTE;
		end
	end

	assign s_axis_tready = !stall;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Byte count of the accepted item; it restarts on a first byte and after
	// a last byte, and holds once it reaches all ones.
	always_comb begin
		cnt_base = s_axis_tuser ? '0 : cnt_q;
		cnt_nx   = (&cnt_base) ? cnt_base : cnt_base + OFFSET_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			cnt_q  <= '0;
		end else if (!stall) begin
			ctl_s1.valid <= accept;
			if (accept) begin
				ctl_s1.start <= s_axis_tuser;
				ctl_s1.last  <= s_axis_tlast;
				cnt_q        <= s_axis_tlast ? '0 : cnt_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_s1 <= cnt_nx;
		end
	end

	// Window cells: the top cell takes the incoming byte, each cell passes
	// its byte one place toward the oldest end on every accepted item.
	assign chain[MAX_PATTERN_BYTES] = s_axis_tdata;

	for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
		wbps_cell #(
			.MAX_BYTES (MAX_PATTERN_BYTES),
			.POS       (k),
			.LEN_W     (LEN_W)
		) u_cell (
			.clk      (clk),
			.shift_en (accept),
			.din      (chain[k+1]),
			.pat_flat (pat_flat),
			.len_eff  (len_eff),
			.dout     (chain[k]),
			.hit      (hits[k])
		);
	end

	assign win_match = &hits;

	wbps_result #(
		.OFFSET_BITS (OFFSET_BITS),
		.LEN_W       (LEN_W)
	) u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_s1        (ctl_s1),
		.cnt_s1        (cnt_s1),
		.len_eff       (len_eff),
		.win_match     (win_match),
		.stall         (stall),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: design/wbps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_cell
// One window position: holds a byte, hands it to its older neighbor on each
// shift and compares it with the pattern byte aligned to this position.
// ----------------------------------------------------------------------------
module wbps_cell #(
	parameter int MAX_BYTES = 16,
	parameter int POS       = 0,
	parameter int LEN_W     = 5
) (
	input  logic                   clk,
	input  logic                   shift_en,
	input  logic [7:0]             din,
	input  logic [MAX_BYTES*8-1:0] pat_flat,
	input  logic [LEN_W-1:0]       len_eff,
	output logic [7:0]             dout,
	output logic                   hit
);
	import wbps_pkg::*;

	localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam logic [LEN_W:0] POS_C = (LEN_W + 1)'(POS);
	localparam logic [LEN_W:0] MAX_C = (LEN_W + 1)'(MAX_BYTES);

	logic [7:0]     byte_q;
	logic [LEN_W:0] sum;
	logic [LEN_W:0] idx_full;
	logic [IDX_W-1:0] idx;
	logic           used;
	logic [7:0]     pat;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= din;
		end
	end

	// The newest len_eff cells line up with pattern bytes 0 .. len_eff-1.
	always_comb begin
		sum      = POS_C + {1'b0, len_eff};
		used     = (sum >= MAX_C);
		idx_full = sum - MAX_C;
		idx      = idx_full[IDX_W-1:0];
		pat      = pat_flat[idx*8 +: 8];
		hit      = !used || (pat == WILDCARD_BYTE) || (pat == byte_q);
	end

	assign dout = byte_q;

endmodule

FILE: design/wbps_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_result
// Second stage: latches the first match of a region and builds the result
// item in the output register on the last byte.
// ----------------------------------------------------------------------------
module wbps_result #(
	parameter int OFFSET_BITS = 32,
	parameter int LEN_W       = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wbps_pkg::item_ctl_t              ctl_s1,
	input  logic [OFFSET_BITS-1:0]           cnt_s1,
	input  logic [LEN_W-1:0]                 len_eff,
	input  logic                             win_match,
	output logic                             stall,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [wbps_pkg::OFFSET_OUT_W-1:0] m_axis_tdata,
	output logic [1:0]                       m_axis_tuser
);
	import wbps_pkg::*;

	localparam int EXT_W = (OFFSET_BITS > OFFSET_OUT_W) ? OFFSET_BITS : OFFSET_OUT_W;

	logic                   match_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic                   valid_q;
	logic [OFFSET_OUT_W-1:0] data_q;
	status_t                status_q;

	logic                   latched_in;
	logic [OFFSET_BITS-1:0] len_ext;
	logic                   long_enough;
	logic                   hit;
	logic                   latch_nx;
	logic [OFFSET_BITS-1:0] offset_nx;
	logic [EXT_W-1:0]       offset_ext;
	status_t                status_nx;
	logic [OFFSET_OUT_W-1:0] data_nx;

	always_comb begin
		latched_in  = ctl_s1.start ? 1'b0 : match_q;
		len_ext     = OFFSET_BITS'(len_eff);
		long_enough = (cnt_s1 >= len_ext);
		hit         = (len_eff != '0) && long_enough && win_match;
		latch_nx    = latched_in || hit;
		offset_nx   = latched_in ? offset_q : (cnt_s1 - len_ext);
		offset_ext  = EXT_W'(offset_nx);
		data_nx     = '0;
		priority if (len_eff == '0) begin
			status_nx = ST_EMPTY;
		end else if (!long_enough) begin
			status_nx = ST_SHORT;
		end else if (latch_nx) begin
			status_nx = ST_FOUND;
			data_nx   = offset_ext[OFFSET_OUT_W-1:0];
		end else begin
			status_nx = ST_NOT_FOUND;
		end
	end

	// Only a last byte needs the output register.
	assign stall = ctl_s1.valid && ctl_s1.last && valid_q && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (valid_q && m_axis_tready) begin
				valid_q <= 1'b0;
			end
			if (ctl_s1.valid && !stall) begin
				if (ctl_s1.last) begin
					valid_q <= 1'b1;
					match_q <= 1'b0;
				end else begin
					match_q <= latch_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid && !stall) begin
			offset_q <= offset_nx;
			if (ctl_s1.last) begin
				status_q <= status_nx;
				data_q   <= data_nx;
			end
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = status_q;

endmodule
